// ----- hdl/met_pkg.sv -----
// ----------------------------------------------------------------------------
// Escape-time unit package
// Shared widths, fixed-point constants, register codes, types and saturating
// arithmetic for the pixel mapper, the point queue and the iteration engine.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int WORD_W    = 64;
  localparam int FRAC_BITS = 56;
  localparam int MAX_SIZE  = 4096;
  localparam int PIX_W     = 12;
  localparam int SPAN_W    = 63;
  localparam int SIZE_W    = 13;
  localparam int ITER_W    = 16;
  localparam int DIV_W     = $clog2(MAX_SIZE + 1);
  localparam int PROD_W    = SPAN_W + PIX_W;
  localparam int STEP_W    = $clog2(PROD_W);
  localparam int MUL_LAT   = 3;
  localparam int MUL_CNT_W = $clog2(MUL_LAT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_W = 6;

  localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] FOUR    = 64'd4 << FRAC_BITS;

  // Default view: the square from -2+2i to 2-2i
  localparam logic [WORD_W-1:0] ORIGIN_X_RST = 64'd0 - (64'd2 << FRAC_BITS);
  localparam logic [WORD_W-1:0] ORIGIN_Y_RST = 64'd2 << FRAC_BITS;
  localparam logic [SPAN_W-1:0] SPAN_RST     = 63'd4 << FRAC_BITS;
  localparam logic [SIZE_W-1:0] SIZE_RST     = 13'd1000;
  localparam logic [ITER_W-1:0] ITER_RST     = 16'd200;

  // Register index codes (byte address / 8)
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_SPAN       = 3'd2;
  localparam logic [2:0] REG_IMAGE_SIZE = 3'd3;
  localparam logic [2:0] REG_MAX_ITER   = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] c_re;
    logic [WORD_W-1:0] c_im;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL,
    FR_DIV,
    FR_ADD,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    IT_IDLE,
    IT_MUL,
    IT_EVAL,
    IT_STEP
  } iter_state_t;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] s;
    s = a + b;
    if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1]) begin
      return a[WORD_W-1] ? NEG_MIN : POS_MAX;
    end
    return s;
  endfunction

  function automatic logic [WORD_W-1:0] sat_sub(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] s;
    s = a - b;
    if (a[WORD_W-1] != b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1]) begin
      return a[WORD_W-1] ? NEG_MIN : POS_MAX;
    end
    return s;
  endfunction

endpackage

// ----- hdl/met_front.sv -----
// ----------------------------------------------------------------------------
// Pixel mapper
// Accepts a pixel request, forms span*index, divides by the clamped image
// size with a restoring divider one bit per cycle and offsets the origins.
// ----------------------------------------------------------------------------
module met_front import met_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PIX_W-1:0]    pixel_column,
  input  logic [PIX_W-1:0]    pixel_row,
  output logic                busy,
  input  logic [WORD_W-1:0]   origin_x,
  input  logic [WORD_W-1:0]   origin_y,
  input  logic [SPAN_W-1:0]   span,
  input  logic [SIZE_W-1:0]   image_size,
  input  queue_status_t       q_status,
  output logic                push,
  output point_t              push_data
);

  front_state_t        state, state_next;
  logic [STEP_W-1:0]   step;
  logic [PIX_W-1:0]    col, row;
  logic [DIV_W-1:0]    divisor;
  logic [PROD_W-1:0]   prod_c, prod_r;
  logic [DIV_W-1:0]    rem_c, rem_r;
  point_t              point;

  logic                accept;
  logic [DIV_W:0]      step_c, step_r;
  logic [WORD_W-1:0]   off_c, off_r;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic             bit_in,
                                              input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    t    = {rem, bit_in};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, diff[DIV_W-1:0]};
    end
    return {1'b0, t[DIV_W-1:0]};
  endfunction

  // Saturate a quotient to the positive range
  function automatic logic [WORD_W-1:0] clip_offset(input logic [PROD_W-1:0] q);
    if (|q[PROD_W-1:WORD_W-1]) begin
      return POS_MAX;
    end
    return {1'b0, q[WORD_W-2:0]};
  endfunction

  assign step_c = div_step(rem_c, prod_c[PROD_W-1], divisor);
  assign step_r = div_step(rem_r, prod_r[PROD_W-1], divisor);
  assign off_c  = clip_offset(prod_c);
  assign off_r  = clip_offset(prod_r);

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (start) state_next = FR_MUL;
      FR_MUL:  state_next = FR_DIV;
      FR_DIV:  if (step == '0) state_next = FR_ADD;
      FR_ADD:  state_next = FR_PUSH;
      FR_PUSH: if (!q_status.full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != FR_IDLE);
    accept = (state == FR_IDLE) && start;
    push   = (state == FR_PUSH) && !q_status.full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == FR_MUL) begin
        step <= STEP_W'(PROD_W - 1);
      end else if (state == FR_DIV) begin
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col <= pixel_column;
      row <= pixel_row;
      if (image_size == '0) begin
        divisor <= DIV_W'(1);
      end else if (int'(image_size) > MAX_SIZE) begin
        divisor <= DIV_W'(MAX_SIZE);
      end else begin
        divisor <= DIV_W'(image_size);
      end
    end
    if (state == FR_MUL) begin
      prod_c <= PROD_W'(span) * PROD_W'(col);
      prod_r <= PROD_W'(span) * PROD_W'(row);
      rem_c  <= '0;
      rem_r  <= '0;
    end else if (state == FR_DIV) begin
      // shift the dividend out the top and the quotient in the bottom
      prod_c <= {prod_c[PROD_W-2:0], step_c[DIV_W]};
      prod_r <= {prod_r[PROD_W-2:0], step_r[DIV_W]};
      rem_c  <= step_c[DIV_W-1:0];
      rem_r  <= step_r[DIV_W-1:0];
    end
    if (state == FR_ADD) begin
      point.c_re <= sat_add(origin_x, off_c);
      point.c_im <= sat_sub(origin_y, off_r);
    end
  end

  assign push_data = point;

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("mapper pushed into a full queue");

  a_div_runs_full_length: assert property (@(posedge clk) disable iff (rst)
    $rose(state == FR_ADD) |-> $past(step == '0))
    else $error("division left before its last step");

endmodule

// ----- hdl/met_queue.sv -----
// ----------------------------------------------------------------------------
// Point queue
// Short first-in first-out buffer of mapped points between the pixel mapper
// and the iteration engine.
// ----------------------------------------------------------------------------
module met_queue import met_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  point_t        push_data,
  input  logic          pop,
  output point_t        pop_data,
  output queue_status_t status
);

  point_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign pop_data     = entries[rptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= next_ptr(wptr);
      end
      if (pop) begin
        rptr <= next_ptr(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- hdl/met_fxmul.sv -----
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Three-stage signed 64x64 product: four 32-bit partial products, one wide
// sum, then truncation toward zero and saturation to 64 bits.
// ----------------------------------------------------------------------------
module met_fxmul import met_pkg::*; (
  input  logic              clk,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [WORD_W-1:0] p
);

  localparam int HALF_W = WORD_W / 2;
  localparam int FULL_W = 2 * WORD_W;
  localparam int TR_W   = FULL_W - FRAC_BITS;

  logic [WORD_W-1:0]         ll;
  logic signed [WORD_W:0]    lh, hl;
  logic signed [WORD_W-1:0]  hh;
  logic [FULL_W-1:0]         prod;

  logic [FULL_W-1:0]         lh_x, hl_x;
  logic [TR_W-1:0]           fl, t;
  logic                      sticky;
  logic [TR_W-WORD_W:0]      top;

  // Stage 1: partial products, low halves unsigned, high halves signed
  always_ff @(posedge clk) begin
    ll <= {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
    lh <= $signed({1'b0, a[HALF_W-1:0]}) * $signed(b[WORD_W-1:HALF_W]);
    hl <= $signed(a[WORD_W-1:HALF_W]) * $signed({1'b0, b[HALF_W-1:0]});
    hh <= $signed(a[WORD_W-1:HALF_W]) * $signed(b[WORD_W-1:HALF_W]);
  end

  assign lh_x = {{(FULL_W-WORD_W-1){lh[WORD_W]}}, lh};
  assign hl_x = {{(FULL_W-WORD_W-1){hl[WORD_W]}}, hl};

  // Stage 2: high and low partials do not overlap, so they concatenate
  always_ff @(posedge clk) begin
    prod <= {hh, ll} + {lh_x[FULL_W-HALF_W-1:0], {HALF_W{1'b0}}}
                     + {hl_x[FULL_W-HALF_W-1:0], {HALF_W{1'b0}}};
  end

  // Stage 3: floor shift, bump negatives with dropped bits toward zero, clamp
  assign fl     = prod[FULL_W-1:FRAC_BITS];
  assign sticky = prod[FULL_W-1] & (|prod[FRAC_BITS-1:0]);
  assign t      = fl + TR_W'(sticky);
  assign top    = t[TR_W-1:WORD_W-1];

  always_ff @(posedge clk) begin
    if (top == '0 || top == '1) begin
      p <= t[WORD_W-1:0];
    end else begin
      p <= t[TR_W-1] ? NEG_MIN : POS_MAX;
    end
  end

endmodule

// ----- hdl/met_iter.sv -----
// ----------------------------------------------------------------------------
// Iteration engine
// Takes a mapped point from the queue and runs z = z*z + c, testing
// re^2 + im^2 >= 4 after each step, until escape or the step limit.
// ----------------------------------------------------------------------------
module met_iter import met_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [ITER_W-1:0]   max_iterations,
  input  queue_status_t       q_status,
  output logic                pop,
  input  point_t              pop_data,
  output logic                done,
  output logic [ITER_W-1:0]   escape_count
);

  iter_state_t           state, state_next;
  logic [MUL_CNT_W-1:0]  mul_cnt;
  point_t                c;
  logic [WORD_W-1:0]     z_re, z_im;
  logic [WORD_W-1:0]     d_re, d_im;
  logic [ITER_W-1:0]     n;

  logic [WORD_W-1:0]     re2, im2, reim, mag;
  logic                  escaped, stop, finish, advance;

  met_fxmul u_mul_re2 (.clk(clk), .a(z_re), .b(z_re), .p(re2));
  met_fxmul u_mul_im2 (.clk(clk), .a(z_im), .b(z_im), .p(im2));
  met_fxmul u_mul_rei (.clk(clk), .a(z_re), .b(z_im), .p(reim));

  // The squares of z_n test step n; z_0 = 0 never escapes
  assign mag     = sat_add(re2, im2);
  assign escaped = !mag[WORD_W-1] && (mag >= FOUR);
  assign stop    = escaped || (n == max_iterations);

  always_comb begin
    state_next = state;
    unique case (state)
      IT_IDLE: if (!q_status.empty) state_next = IT_MUL;
      IT_MUL:  if (mul_cnt == MUL_CNT_W'(MUL_LAT - 1)) state_next = IT_EVAL;
      IT_EVAL: state_next = stop ? IT_IDLE : IT_STEP;
      IT_STEP: state_next = IT_MUL;
      default: state_next = IT_IDLE;
    endcase
  end

  always_comb begin
    pop     = (state == IT_IDLE) && !q_status.empty;
    finish  = (state == IT_EVAL) && stop;
    advance = (state == IT_EVAL) && !stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IT_IDLE;
      mul_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= finish;
      if (state == IT_MUL) begin
        mul_cnt <= mul_cnt + 1'b1;
      end else begin
        mul_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      c    <= pop_data;
      z_re <= '0;
      z_im <= '0;
      n    <= '0;
    end
    if (advance) begin
      d_re <= sat_sub(re2, im2);
      d_im <= sat_add(reim, reim);
    end
    if (state == IT_STEP) begin
      z_re <= sat_add(d_re, c.c_re);
      z_im <= sat_add(d_im, c.c_im);
      n    <= n + 1'b1;
    end
    if (finish) begin
      escape_count <= escaped ? n : '0;
    end
  end

  a_done_after_eval: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == IT_EVAL))
    else $error("result strobe without a finished evaluation");

  a_count_in_limit: assert property (@(posedge clk) disable iff (rst)
    (done && escape_count != '0) |-> escape_count <= max_iterations)
    else $error("escape count beyond the step limit");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("engine popped an empty queue");

endmodule

// ----- hdl/mandelbrot_escape_time_unit.sv -----
// Pixel mapping of each request runs through the 75-step restoring divider.
// Each z loop step runs the three-stage product pipeline, then evaluate, then
// update; a two-entry point queue lets mapping of the next request overlap the z loop.
// busy is high while the mapper holds a request; done pulses for one cycle.
// Reset: synchronous; clears control state and loads the default -2+2i view.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Top level: configuration registers on an APB-style port, pixel mapper,
// point queue and iteration engine.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit import met_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PIX_W-1:0]       pixel_column,
  input  logic [PIX_W-1:0]       pixel_row,
  output logic                   busy,
  output logic                   done,
  output logic [ITER_W-1:0]      escape_count,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [WORD_W-1:0]      pwdata,
  output logic [WORD_W-1:0]      prdata,
  output logic                   pready
);

  logic [WORD_W-1:0]  origin_x, origin_y;
  logic [SPAN_W-1:0]  span;
  logic [SIZE_W-1:0]  image_size;
  logic [ITER_W-1:0]  max_iterations;

  logic [2:0]         reg_index;
  logic               cfg_write;

  logic               push, pop;
  point_t             push_data, pop_data;
  queue_status_t      q_status;

  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= ORIGIN_X_RST;
      origin_y       <= ORIGIN_Y_RST;
      span           <= SPAN_RST;
      image_size     <= SIZE_RST;
      max_iterations <= ITER_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ORIGIN_X:   origin_x       <= pwdata;
        REG_ORIGIN_Y:   origin_y       <= pwdata;
        REG_SPAN:       span           <= pwdata[SPAN_W-1:0];
        REG_IMAGE_SIZE: image_size     <= pwdata[SIZE_W-1:0];
        REG_MAX_ITER:   max_iterations <= pwdata[ITER_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ORIGIN_X:   prdata = origin_x;
      REG_ORIGIN_Y:   prdata = origin_y;
      REG_SPAN:       prdata = WORD_W'(span);
      REG_IMAGE_SIZE: prdata = WORD_W'(image_size);
      REG_MAX_ITER:   prdata = WORD_W'(max_iterations);
      default:        prdata = '0;
    endcase
  end

  met_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .busy         (busy),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .span         (span),
    .image_size   (image_size),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  met_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  met_iter u_iter (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (max_iterations),
    .q_status       (q_status),
    .pop            (pop),
    .pop_data       (pop_data),
    .done           (done),
    .escape_count   (escape_count)
  );

endmodule
